@@ sv/cell_automaton_implication_assert.svh @@
// Assertion macros for the cell automaton implication block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CELL_AUTOMATON_IMPLICATION_ASSERT_SVH
`define CELL_AUTOMATON_IMPLICATION_ASSERT_SVH

`ifndef SYNTHESIS
`define CAI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("cell_automaton_implication: assertion failed");
`define CAI_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("cell_automaton_implication: forbidden condition");
`else
`define CAI_ASSERT(label, prop)
`define CAI_ASSERT_NEVER(label, expr)
`endif

`endif

@@ sv/cai_pkg.sv @@
// Shared types and constants for the cell automaton implication block.
// No dependencies.
package cai_pkg;

	localparam int unsigned NBR_COUNT = 8;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned SUM_W     = 5;
	localparam int unsigned MASK_W    = NBR_COUNT + 1;
	localparam int unsigned IN_W      = 16;
	localparam int unsigned OUT_W     = 8;

	localparam logic [1:0] ST_OFF = 2'd0;
	localparam logic [1:0] ST_ON  = 2'd1;
	localparam logic [1:0] ST_UNK = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;

	localparam logic REG_BIRTH   = 1'b0;
	localparam logic REG_SURVIVE = 1'b1;

	localparam logic [MASK_W-1:0] BIRTH_RST   = MASK_W'(8);
	localparam logic [MASK_W-1:0] SURVIVE_RST = MASK_W'(12);

	typedef struct packed {
		logic [CNT_W-1:0] unknown_neighbours;
		logic [CNT_W-1:0] on_neighbours;
		logic [1:0]       center_state;
		logic [1:0]       future_state;
	} cai_query_t;

	typedef struct packed {
		logic consistent;
		logic future_forced;
		logic future_value;
		logic center_forced;
		logic center_value;
		logic neighbours_forced;
		logic neighbours_value;
	} cai_result_t;

	typedef struct packed {
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
	} cai_rule_t;

endpackage

@@ sv/cai_cfg.sv @@
// Rule register file: birth and survival masks behind a plain write port.
// Depends on cai_pkg.
module cai_cfg import cai_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MASK_W-1:0] cfg_data,
	output cai_rule_t         rule
);

	logic [MASK_W-1:0] birth_q;
	logic [MASK_W-1:0] survive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= BIRTH_RST;
			survive_q <= SURVIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIRTH:   birth_q   <= cfg_data;
				REG_SURVIVE: survive_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rule.birth   = birth_q;
	assign rule.survive = survive_q;

endmodule

@@ sv/cai_eval.sv @@
// Evaluates all completions of one cell query in parallel, one lane per
// neighbour count, and reduces them to consistency and forced values.
// Depends on cai_pkg.
module cai_eval import cai_pkg::*; (
	input  cai_query_t  query,
	input  cai_rule_t   rule,
	output cai_result_t result
);

	always_comb begin
		logic [SUM_W-1:0]  hi;
		logic [SUM_W-1:0]  lo;
		logic [MASK_W-1:0] ok0;
		logic [MASK_W-1:0] ok1;
		logic [MASK_W-1:0] hit;
		logic [MASK_W-1:0] gt_lo;
		logic [MASK_W-1:0] lt_hi;
		logic              bad;
		logic              c0_ok, c1_ok, f0_ok, f1_ok;
		logic              f0_hit, f1_hit, valid;
		logic              c_on, c_off, f_on, f_off, n_on, n_off;
		logic              rng;

		lo  = {1'b0, query.on_neighbours};
		hi  = {1'b0, query.unknown_neighbours} + lo;
		bad = (hi > SUM_W'(NBR_COUNT)) || (query.center_state == ST_BAD)
			|| (query.future_state == ST_BAD);

		c0_ok = query.center_state != ST_ON;
		c1_ok = query.center_state != ST_OFF;
		f0_ok = query.future_state != ST_ON;
		f1_ok = query.future_state != ST_OFF;

		f0_hit = 1'b0;
		f1_hit = 1'b0;
		for (int i = 0; i < MASK_W; i++) begin
			rng      = (SUM_W'(i) >= lo) && (SUM_W'(i) <= hi);
			ok0[i]   = rng && c0_ok && (rule.birth[i] ? f1_ok : f0_ok);
			ok1[i]   = rng && c1_ok && (rule.survive[i] ? f1_ok : f0_ok);
			gt_lo[i] = SUM_W'(i) > lo;
			lt_hi[i] = SUM_W'(i) < hi;
			f1_hit   = f1_hit | (ok0[i] & rule.birth[i]) | (ok1[i] & rule.survive[i]);
			f0_hit   = f0_hit | (ok0[i] & ~rule.birth[i]) | (ok1[i] & ~rule.survive[i]);
		end
		hit = ok0 | ok1;

		valid = !bad && (|hit);
		c_on  = ~|ok0;
		c_off = ~|ok1;
		f_on  = !f0_hit;
		f_off = !f1_hit;
		n_off = ~|(hit & gt_lo);
		n_on  = ~|(hit & lt_hi);

		result                   = '0;
		result.consistent        = valid;
		if (valid) begin
			if (query.future_state == ST_UNK && (f_on || f_off)) begin
				result.future_forced = 1'b1;
				result.future_value  = f_on;
			end
			if (query.center_state == ST_UNK && (c_on || c_off)) begin
				result.center_forced = 1'b1;
				result.center_value  = c_on;
			end
			if (query.unknown_neighbours != '0 && (n_on || n_off)) begin
				result.neighbours_forced = 1'b1;
				result.neighbours_value  = n_on;
			end
		end
	end

endmodule

@@ sv/cell_automaton_implication.sv @@
// Path: an accepted transaction is registered in s1, evaluated, then registered in s2 and offered as a result.
// Throughput: one transaction per cycle unless a waiting result stalls the output, set by the single-pass evaluation.
// Backpressure: with a result waiting, one more transaction is taken into s1, then input stalls.
// Reset (arst_n low, asynchronous): both stages empty, birth mask 8, survival mask 12.
// Top level of the cell automaton implication block; uses cai_pkg, cai_cfg, cai_eval.
`include "cell_automaton_implication_assert.svh"
module cell_automaton_implication import cai_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [MASK_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	// unknown_neighbours[3:0], on_neighbours[7:4], center_state[9:8],
	// future_state[11:10], zero[15:12]
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// consistent[0], future_forced[1], future_value[2], center_forced[3],
	// center_value[4], neighbours_forced[5], neighbours_value[6], zero[7]
	output logic [OUT_W-1:0]  m_tdata
);

	cai_rule_t   rule;
	cai_query_t  query_in;
	cai_query_t  query_s1;
	cai_result_t result;
	cai_result_t result_s2;
	logic        valid_s1;
	logic        valid_s2;
	logic        s2_ready;
	logic        s1_adv;

	cai_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rule      (rule)
	);

	assign query_in.unknown_neighbours = s_tdata[3:0];
	assign query_in.on_neighbours      = s_tdata[7:4];
	assign query_in.center_state       = s_tdata[9:8];
	assign query_in.future_state       = s_tdata[11:10];

	assign s2_ready = !valid_s2 || m_tready;
	assign s1_adv   = valid_s1 && s2_ready;
	assign s_tready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (s2_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			query_s1 <= query_in;
		if (s1_adv)
			result_s2 <= result;
	end

	cai_eval u_eval (
		.query  (query_s1),
		.rule   (rule),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0,
		result_s2.neighbours_value, result_s2.neighbours_forced,
		result_s2.center_value, result_s2.center_forced,
		result_s2.future_value, result_s2.future_forced,
		result_s2.consistent};

	`CAI_ASSERT(a_inconsistent_clear, (m_tvalid && !m_tdata[0]) |-> (m_tdata[7:1] == '0))
	`CAI_ASSERT(a_value_needs_forced, (m_tvalid && m_tdata[6]) |-> m_tdata[5])
	`CAI_ASSERT(a_accept_fills_s1, (s_tvalid && s_tready) |=> valid_s1)
	`CAI_ASSERT_NEVER(a_stall_when_empty, !s_tready && !(valid_s1 && valid_s2))

endmodule
